FILE: sv/kred_pkg.sv
// Package: types, codes and helpers for the keyboard report event differ.
package kred_pkg;

	localparam int KEY_SLOTS = 6;
	localparam int MOD_STEPS = 6;
	localparam int IDX_W = ($clog2(KEY_SLOTS) > $clog2(MOD_STEPS)) ?
		$clog2(KEY_SLOTS) : $clog2(MOD_STEPS);

	localparam logic [7:0] MOD_CTRL_MASK  = 8'h11;
	localparam logic [7:0] MOD_SHIFT_MASK = 8'h22;
	localparam logic [7:0] MOD_ALT_MASK   = 8'h44;

	localparam logic [7:0] KEY_CTRL  = 8'hE0;
	localparam logic [7:0] KEY_SHIFT = 8'hE1;
	localparam logic [7:0] KEY_ALT   = 8'hE2;

	localparam logic [7:0] USAGE_A     = 8'h04;
	localparam logic [7:0] USAGE_Z     = 8'h1D;
	localparam logic [7:0] USAGE_1     = 8'h1E;
	localparam logic [7:0] USAGE_9     = 8'h26;
	localparam logic [7:0] USAGE_0     = 8'h27;
	localparam logic [7:0] USAGE_BKSP  = 8'h2A;
	localparam logic [7:0] USAGE_SPACE = 8'h2C;

	localparam logic [6:0] CH_UPPER_A = 7'h41;
	localparam logic [6:0] CH_LOWER_A = 7'h61;
	localparam logic [6:0] CH_ONE     = 7'h31;
	localparam logic [6:0] CH_ZERO    = 7'h30;
	localparam logic [6:0] CH_SPACE   = 7'h20;
	localparam logic [6:0] CH_BKSP    = 7'h08;
	localparam logic [6:0] CH_NONE    = 7'h00;

	localparam logic [1:0] PAIR_SHIFT = 2'd0;
	localparam logic [1:0] PAIR_CTRL  = 2'd1;
	localparam logic [1:0] PAIR_ALT   = 2'd2;

	typedef struct packed {
		logic [7:0] modifiers;
		logic [7:0] key_slot_0;
		logic [7:0] key_slot_1;
		logic [7:0] key_slot_2;
		logic [7:0] key_slot_3;
		logic [7:0] key_slot_4;
		logic [7:0] key_slot_5;
	} report_t;

	typedef struct packed {
		logic [7:0] event_key;
		logic       key_pressed;
		logic [6:0] char_code;
		logic       last_event;
	} key_event_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MODS,
		ST_RELS,
		ST_PRSS,
		ST_FLUSH
	} state_t;

	function automatic logic [7:0] pair_mask(input logic [1:0] pair);
		logic [7:0] m;
		unique case (pair)
			PAIR_SHIFT: m = MOD_SHIFT_MASK;
			PAIR_CTRL:  m = MOD_CTRL_MASK;
			PAIR_ALT:   m = MOD_ALT_MASK;
			default:    m = '0;
		endcase
		return m;
	endfunction

	function automatic logic [7:0] pair_code(input logic [1:0] pair);
		logic [7:0] c;
		unique case (pair)
			PAIR_SHIFT: c = KEY_SHIFT;
			PAIR_CTRL:  c = KEY_CTRL;
			PAIR_ALT:   c = KEY_ALT;
			default:    c = '0;
		endcase
		return c;
	endfunction

	function automatic logic [6:0] ascii_of(input logic [7:0] code, input logic shifted);
		logic [6:0] ch;
		if (code >= USAGE_A && code <= USAGE_Z) begin
			ch = (shifted ? CH_UPPER_A : CH_LOWER_A) + 7'(code - USAGE_A);
		end else if (code >= USAGE_1 && code <= USAGE_9) begin
			ch = CH_ONE + 7'(code - USAGE_1);
		end else if (code == USAGE_0) begin
			ch = CH_ZERO;
		end else if (code == USAGE_SPACE) begin
			ch = CH_SPACE;
		end else if (code == USAGE_BKSP) begin
			ch = CH_BKSP;
		end else begin
			ch = CH_NONE;
		end
		return ch;
	endfunction

endpackage

FILE: sv/keyboard_report_event_diff_unit.sv
// Top level: boot keyboard report differ with a stepped compare unit.
// Each report takes MOD_STEPS + 2*KEY_SLOTS + 1 steps after it is accepted,
// one step per cycle; a step that finds an event waits while the held item cannot move
// into the output register. The release and press steps share one membership compare unit.
// rpt_stall is low only while idle; the next report may enter while the last item waits.
// Reset clears control, the stored previous report and the output valid.
module keyboard_report_event_diff_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rpt_valid,
	output logic                rpt_stall,
	input  kred_pkg::report_t   rpt,
	output logic                evt_valid,
	input  logic                evt_stall,
	output kred_pkg::key_event_t evt
);
	import kred_pkg::*;

	state_t state_q, state_nxt;
	logic [IDX_W-1:0] idx_q, idx_nxt;

	logic [7:0] cur_mods_q, prev_mods_q;
	logic [7:0] cur_keys_q [KEY_SLOTS];
	logic [7:0] prev_keys_q [KEY_SLOTS];
	logic [7:0] new_keys [KEY_SLOTS];

	key_event_t pend_q, out_q, ev;
	logic pend_valid_q, out_valid_q;

	logic rpt_take, can_push, hit, advance, push_out, done;
	logic [7:0] probe, rel_mods, prs_mods;
	logic holds;
	logic [1:0] pair;

	assign new_keys[0] = rpt.key_slot_0;
	assign new_keys[1] = rpt.key_slot_1;
	assign new_keys[2] = rpt.key_slot_2;
	assign new_keys[3] = rpt.key_slot_3;
	assign new_keys[4] = rpt.key_slot_4;
	assign new_keys[5] = rpt.key_slot_5;

	assign rpt_stall = (state_q != ST_IDLE);
	assign rpt_take  = rpt_valid && !rpt_stall;
	assign can_push  = !out_valid_q || !evt_stall;
	assign evt_valid = out_valid_q;
	assign evt       = out_q;

	assign rel_mods = prev_mods_q & ~cur_mods_q;
	assign prs_mods = cur_mods_q & ~prev_mods_q;
	assign pair     = idx_q[2:1];

	// shared compare unit: probe key against the opposite report
	always_comb begin
		probe = (state_q == ST_RELS) ? prev_keys_q[idx_q] : cur_keys_q[idx_q];
		holds = 1'b0;
		for (int j = 0; j < KEY_SLOTS; j++) begin
			if (state_q == ST_RELS) begin
				holds = holds | (cur_keys_q[j] == probe);
			end else begin
				holds = holds | (prev_keys_q[j] == probe);
			end
		end
	end

	// step outputs
	always_comb begin
		hit = 1'b0;
		ev  = '0;
		unique case (state_q)
			ST_MODS: begin
				hit = |((idx_q[0] ? prs_mods : rel_mods) & pair_mask(pair));
				ev.event_key   = pair_code(pair);
				ev.key_pressed = idx_q[0];
			end
			ST_RELS: begin
				hit = (probe != 8'h00) && !holds;
				ev.event_key = probe;
			end
			ST_PRSS: begin
				hit = (probe != 8'h00) && !holds;
				ev.event_key   = probe;
				ev.key_pressed = 1'b1;
				ev.char_code   = ascii_of(probe, |(cur_mods_q & MOD_SHIFT_MASK));
			end
			default: begin
				hit = 1'b0;
			end
		endcase
		if (state_q == ST_FLUSH) begin
			advance  = !pend_valid_q || can_push;
			push_out = pend_valid_q && can_push;
		end else begin
			advance  = !hit || !pend_valid_q || can_push;
			push_out = hit && pend_valid_q && can_push;
		end
		done = (state_q == ST_FLUSH) && advance;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		idx_nxt   = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (rpt_take) begin
					state_nxt = ST_MODS;
					idx_nxt   = '0;
				end
			end
			ST_MODS: begin
				if (advance) begin
					if (idx_q == IDX_W'(MOD_STEPS - 1)) begin
						state_nxt = ST_RELS;
						idx_nxt   = '0;
					end else begin
						idx_nxt = idx_q + 1'b1;
					end
				end
			end
			ST_RELS: begin
				if (advance) begin
					if (idx_q == IDX_W'(KEY_SLOTS - 1)) begin
						state_nxt = ST_PRSS;
						idx_nxt   = '0;
					end else begin
						idx_nxt = idx_q + 1'b1;
					end
				end
			end
			ST_PRSS: begin
				if (advance) begin
					if (idx_q == IDX_W'(KEY_SLOTS - 1)) begin
						state_nxt = ST_FLUSH;
						idx_nxt   = '0;
					end else begin
						idx_nxt = idx_q + 1'b1;
					end
				end
			end
			ST_FLUSH: begin
				if (advance) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			prev_mods_q  <= '0;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				prev_keys_q[i] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			idx_q   <= idx_nxt;
			if (push_out) begin
				out_valid_q <= 1'b1;
			end else if (!evt_stall) begin
				out_valid_q <= 1'b0;
			end
			if (hit && advance) begin
				pend_valid_q <= 1'b1;
			end else if (done) begin
				pend_valid_q <= 1'b0;
			end
			if (done) begin
				prev_mods_q <= cur_mods_q;
				for (int i = 0; i < KEY_SLOTS; i++) begin
					prev_keys_q[i] <= cur_keys_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rpt_take) begin
			cur_mods_q <= rpt.modifiers;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				cur_keys_q[i] <= new_keys[i];
			end
		end
		if (hit && advance) begin
			pend_q <= ev;
		end
		if (push_out) begin
			out_q <= key_event_t'{pend_q.event_key, pend_q.key_pressed, pend_q.char_code,
				state_q == ST_FLUSH};
		end
	end

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_valid_q)
		else $error("pending item left over while idle");

	a_last_only_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(push_out && state_q != ST_FLUSH) |=> !out_q.last_event)
		else $error("last flag set on an item that is not final");

	a_release_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.key_pressed) |-> out_q.char_code == CH_NONE)
		else $error("release item carries a character");

endmodule

FILE: sim/tb.sv
// Testbench for the keyboard report differ: drives reports, predicts key events, checks them.
`timescale 1ns / 1ps

module tb;
	import kred_pkg::*;

	class key_event_board;
		logic [7:0] held_mods;
		logic [7:0] held_keys[KEY_SLOTS];
		key_event_t pending[$];
		int errors;

		function new();
			held_mods = '0;
			foreach (held_keys[i]) held_keys[i] = '0;
			errors = 0;
		endfunction

		task report(input string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		function bit holds(input logic [7:0] set[KEY_SLOTS], input logic [7:0] code);
			foreach (set[i]) if (set[i] === code) return 1'b1;
			return 1'b0;
		endfunction

		function logic [6:0] char_for(input logic [7:0] code, input logic shifted);
			if (code inside {[USAGE_A:USAGE_Z]})
				return 7'((shifted ? 8'h41 : 8'h61) + code - USAGE_A);
			if (code inside {[USAGE_1:USAGE_9]})
				return 7'(8'h31 + code - USAGE_1);
			if (code == USAGE_0) return CH_ZERO;
			if (code == USAGE_SPACE) return CH_SPACE;
			if (code == USAGE_BKSP) return CH_BKSP;
			return CH_NONE;
		endfunction

		// shift, ctrl, alt; releases of stale keys; presses of new keys
		task note_report(input report_t r);
			logic [7:0] fresh[KEY_SLOTS];
			logic [7:0] gone, came;
			logic [7:0] masks[3];
			logic [7:0] codes[3];
			logic shifted;
			key_event_t batch[$];
			fresh = '{r.key_slot_0, r.key_slot_1, r.key_slot_2,
				r.key_slot_3, r.key_slot_4, r.key_slot_5};
			masks = '{MOD_SHIFT_MASK, MOD_CTRL_MASK, MOD_ALT_MASK};
			codes = '{KEY_SHIFT, KEY_CTRL, KEY_ALT};
			gone = held_mods & ~r.modifiers;
			came = r.modifiers & ~held_mods;
			shifted = (r.modifiers & MOD_SHIFT_MASK) != 8'h00;
			for (int p = 0; p < 3; p++) begin
				if ((gone & masks[p]) != 8'h00)
					batch.push_back(key_event_t'{codes[p], 1'b0, CH_NONE, 1'b0});
				if ((came & masks[p]) != 8'h00)
					batch.push_back(key_event_t'{codes[p], 1'b1, CH_NONE, 1'b0});
			end
			foreach (held_keys[i])
				if (held_keys[i] != 8'h00 && !holds(fresh, held_keys[i]))
					batch.push_back(key_event_t'{held_keys[i], 1'b0, CH_NONE, 1'b0});
			foreach (fresh[i])
				if (fresh[i] != 8'h00 && !holds(held_keys, fresh[i]))
					batch.push_back(key_event_t'{fresh[i], 1'b1,
						char_for(fresh[i], shifted), 1'b0});
			if (batch.size() > 0) batch[batch.size() - 1].last_event = 1'b1;
			foreach (batch[i]) pending.push_back(batch[i]);
			held_mods = r.modifiers;
			held_keys = fresh;
		endtask

		task check_event(input key_event_t got);
			key_event_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected event key=%02h pressed=%b",
					got.event_key, got.key_pressed));
				return;
			end
			want = pending.pop_front();
			if (got.event_key !== want.event_key)
				report($sformatf("event_key %02h, expected %02h", got.event_key,
					want.event_key));
			if (got.key_pressed !== want.key_pressed)
				report($sformatf("key_pressed %b, expected %b for key %02h",
					got.key_pressed, want.key_pressed, want.event_key));
			if (got.char_code !== want.char_code)
				report($sformatf("char_code %02h, expected %02h for key %02h",
					got.char_code, want.char_code, want.event_key));
			if (got.last_event !== want.last_event)
				report($sformatf("last_event %b, expected %b for key %02h",
					got.last_event, want.last_event, want.event_key));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic rpt_valid;
	logic rpt_stall;
	report_t rpt;
	logic evt_valid;
	logic evt_stall = 1'b0;
	key_event_t evt;

	key_event_board board = new();
	bit steady = 1'b0;
	int stall_left = 0;
	int stall_roll;

	keyboard_report_event_diff_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.rpt_valid(rpt_valid),
		.rpt_stall(rpt_stall),
		.rpt(rpt),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt(evt)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (steady) begin
			evt_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			evt_stall <= 1'b1;
			stall_left--;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 65) begin
				evt_stall <= 1'b0;
			end else begin
				evt_stall <= 1'b1;
				stall_left = (stall_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && evt_valid && !evt_stall) board.check_event(evt);
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic report_t mk(input logic [7:0] m, input logic [7:0] k0,
		input logic [7:0] k1, input logic [7:0] k2, input logic [7:0] k3,
		input logic [7:0] k4, input logic [7:0] k5);
		return report_t'{m, k0, k1, k2, k3, k4, k5};
	endfunction

	// entered and left at a falling edge
	task automatic send(input report_t item, input int gap);
		if (gap > 0) begin
			rpt_valid <= 1'b0;
			rpt <= report_t'(56'({$urandom, $urandom}));
			repeat (gap) @(negedge clk);
		end
		rpt <= item;
		rpt_valid <= 1'b1;
		do @(posedge clk); while (rpt_stall);
		board.note_report(item);
		@(negedge clk);
	endtask

	task automatic drain();
		rpt_valid <= 1'b0;
		@(negedge clk);
		while (board.pending.size() != 0) @(negedge clk);
	endtask

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		report_t plan[$];
		report_t last;
		report_t nxt;
		logic [7:0] slots[KEY_SLOTS];
		logic [7:0] mods;
		int r, s, roll;

		arst_n <= 1'b0;
		rpt_valid <= 1'b0;
		rpt <= '0;
		last = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		plan.push_back(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		plan.push_back(mk(8'h02, 8'h04, 8'h1D, 8'h1E, 8'h26, 8'h27, 8'h2C));
		plan.push_back(mk(8'h20, 8'h2A, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00));
		plan.push_back(mk(8'h20, 8'h2A, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00));
		plan.push_back(mk(8'h11, 8'h00, 8'h2A, 8'h05, 8'h00, 8'h00, 8'h00));
		plan.push_back(mk(8'h88, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06));
		plan.push_back(mk(8'h08, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06));
		plan.push_back(mk(8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		plan.push_back(mk(8'h07, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16));
		plan.push_back(mk(8'h70, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h1B, 8'h1C));
		plan.push_back(mk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		plan.push_back(mk(8'h00, 8'h01, 8'h02, 8'h03, 8'h80, 8'hE0, 8'hE1));
		plan.push_back(mk(8'h00, 8'h1D, 8'h2B, 8'h2D, 8'h00, 8'h28, 8'h3A));
		plan.push_back(mk(8'h40, 8'h1D, 8'h2B, 8'h2D, 8'h00, 8'h28, 8'h3A));
		plan.push_back(mk(8'h04, 8'h1D, 8'h2B, 8'h2D, 8'h00, 8'h28, 8'h3A));
		plan.push_back(mk(8'h10, 8'h2C, 8'h2B, 8'h2D, 8'h27, 8'h28, 8'h3A));
		plan.push_back(mk(8'h01, 8'h2C, 8'h2B, 8'h2D, 8'h27, 8'h28, 8'h3A));
		plan.push_back(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		foreach (plan[i]) begin
			send(plan[i], pick_gap());
			last = plan[i];
		end
		drain();

		// mostly typing-like deltas, some repeats, some full noise
		for (int n = 0; n < 280; n++) begin
			steady = ((n / 40) % 3 == 1);
			slots = '{last.key_slot_0, last.key_slot_1, last.key_slot_2,
				last.key_slot_3, last.key_slot_4, last.key_slot_5};
			mods = last.modifiers;
			r = $urandom_range(0, 99);
			if (r >= 10 && r < 22) begin
				mods = 8'($urandom);
				foreach (slots[i]) slots[i] = 8'($urandom);
			end else if (r >= 22) begin
				if ($urandom_range(0, 2) == 0) mods ^= 8'(1 << $urandom_range(0, 7));
				repeat ($urandom_range(1, 2)) begin
					s = $urandom_range(0, KEY_SLOTS - 1);
					roll = $urandom_range(0, 99);
					if (roll < 40)
						slots[s] = 8'h00;
					else if (roll < 85)
						slots[s] = 8'($urandom_range(USAGE_A, USAGE_SPACE));
					else if (roll < 93)
						slots[s] = slots[$urandom_range(0, KEY_SLOTS - 1)];
					else
						slots[s] = 8'($urandom);
				end
			end
			nxt = mk(mods, slots[0], slots[1], slots[2], slots[3], slots[4], slots[5]);
			send(nxt, pick_gap());
			last = nxt;
			if (n % 70 == 69) drain();
		end
		steady = 1'b0;

		rpt_valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (board.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: files.f
sv/kred_pkg.sv
sv/keyboard_report_event_diff_unit.sv
sim/tb.sv
